@@ hdl/thrp_pkg.sv @@
// ----------------------------------------------------------------------------
// thrp_pkg
// Shared types and constants for the tagged hash record parser.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package thrp_pkg;

  // default record geometry
  localparam int DEF_SHORT_LEN   = 20;
  localparam int DEF_LONG_LEN    = 32;
  localparam int DEF_MAX_RECORDS = 32;

  localparam int BYTE_W   = 8;
  localparam int POS_W    = 6;
  localparam int REC_W    = 8;
  localparam int TDATA_W  = 32;
  localparam int TUSER_W  = 2;

  // record tags
  localparam logic [BYTE_W-1:0] TAG_SHORT = 8'd0;
  localparam logic [BYTE_W-1:0] TAG_LONG  = 8'd1;

  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_BAD_TAG    = 2'd1,
    ST_TRUNCATED  = 2'd2,
    ST_OVER_LIMIT = 2'd3
  } status_t;

  typedef struct packed {
    logic [BYTE_W-1:0] hash_byte;
    logic              is_hash;
    logic              kind;
    logic [REC_W-1:0]  record_number;
    logic [POS_W-1:0]  byte_position;
    logic              record_done;
    logic              packet_end;
    status_t           status;
  } result_t;

endpackage

@@ hdl/thrp_parse.sv @@
// ----------------------------------------------------------------------------
// thrp_parse
// Per-packet parse state and the combinational decode of one packet byte.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module thrp_parse #(
  parameter int SHORT_LEN   = thrp_pkg::DEF_SHORT_LEN,
  parameter int LONG_LEN    = thrp_pkg::DEF_LONG_LEN,
  parameter int MAX_RECORDS = thrp_pkg::DEF_MAX_RECORDS
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        step,
  input  logic [thrp_pkg::BYTE_W-1:0] data_byte,
  input  logic                        last_byte,
  output thrp_pkg::result_t           result
);

  localparam logic [thrp_pkg::POS_W:0]   SHORT_LEN_V = (thrp_pkg::POS_W+1)'(SHORT_LEN);
  localparam logic [thrp_pkg::POS_W:0]   LONG_LEN_V  = (thrp_pkg::POS_W+1)'(LONG_LEN);
  localparam logic [thrp_pkg::REC_W-1:0] MAX_REC_V   = thrp_pkg::REC_W'(MAX_RECORDS);
  localparam logic [thrp_pkg::REC_W-1:0] REC_SAT     = '1;

  logic                       in_body, in_body_next;
  logic                       current_kind, current_kind_next;
  logic [thrp_pkg::POS_W-1:0] body_count, body_count_next;
  logic [thrp_pkg::REC_W-1:0] record_count, record_count_next;
  thrp_pkg::status_t          error_code, error_code_next;

  logic [thrp_pkg::POS_W:0]   body_len;
  logic [thrp_pkg::POS_W:0]   count_inc;

  assign body_len  = current_kind ? LONG_LEN_V : SHORT_LEN_V;
  assign count_inc = {1'b0, body_count} + 1'b1;

  always_comb begin
    result            = '0;
    in_body_next      = in_body;
    current_kind_next = current_kind;
    body_count_next   = body_count;
    record_count_next = record_count;
    error_code_next   = error_code;

    if (error_code == thrp_pkg::ST_OK) begin
      if (!in_body) begin
        if (record_count >= MAX_REC_V) begin
          error_code_next = thrp_pkg::ST_OVER_LIMIT;
        end else if (data_byte == thrp_pkg::TAG_SHORT || data_byte == thrp_pkg::TAG_LONG) begin
          in_body_next      = 1'b1;
          current_kind_next = data_byte[0];
          body_count_next   = '0;
        end else begin
          error_code_next = thrp_pkg::ST_BAD_TAG;
        end
      end else begin
        result.hash_byte     = data_byte;
        result.is_hash       = 1'b1;
        result.kind          = current_kind;
        result.record_number = record_count;
        result.byte_position = body_count;
        if (count_inc >= body_len) begin
          result.record_done = 1'b1;
          in_body_next       = 1'b0;
          body_count_next    = '0;
          if (record_count != REC_SAT) begin
            record_count_next = record_count + 1'b1;
          end
        end else begin
          body_count_next = count_inc[thrp_pkg::POS_W-1:0];
        end
      end
    end

    // end of packet: report and return to the idle state
    if (last_byte) begin
      result.packet_end = 1'b1;
      if (error_code_next != thrp_pkg::ST_OK) begin
        result.status = error_code_next;
      end else if (in_body_next) begin
        result.status = thrp_pkg::ST_TRUNCATED;
      end else begin
        result.status = thrp_pkg::ST_OK;
      end
      in_body_next      = 1'b0;
      current_kind_next = 1'b0;
      body_count_next   = '0;
      record_count_next = '0;
      error_code_next   = thrp_pkg::ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_body      <= 1'b0;
      current_kind <= 1'b0;
      body_count   <= '0;
      record_count <= '0;
      error_code   <= thrp_pkg::ST_OK;
    end else if (step) begin
      in_body      <= in_body_next;
      current_kind <= current_kind_next;
      body_count   <= body_count_next;
      record_count <= record_count_next;
      error_code   <= error_code_next;
    end
  end

endmodule

@@ hdl/tagged_hash_record_parser_core.sv @@
// ----------------------------------------------------------------------------
// tagged_hash_record_parser_core
// Byte-stream parser for packets of tagged short/long hash records.
// ----------------------------------------------------------------------------
// Input: one packet byte per request on s_*, s_tlast marks the packet's last
// byte. Output: one result per input byte on m_*; m_tuser flags hash bytes
// and their record kind, m_tlast marks the packet end, where m_tdata also
// carries the packet status (accepted, bad tag, truncated, over limit).
// A byte passes through the input register, the decode against the parse
// state, then the result register. Throughput is one byte per cycle while
// the receiver does not stall; the registered parse state feeds back into
// its own update; the input register loads when empty or the output advances.
// When the receiver stalls, the output register holds its result and the
// input register holds one more byte; s_tready drops once both are full.
// Reset clears both valid flags and returns the parse state to "expecting a
// tag, no records, no error". Each packet end also resets the parse state.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tagged_hash_record_parser_core #(
  parameter int SHORT_LEN   = thrp_pkg::DEF_SHORT_LEN,
  parameter int LONG_LEN    = thrp_pkg::DEF_LONG_LEN,
  parameter int MAX_RECORDS = thrp_pkg::DEF_MAX_RECORDS
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         s_tvalid,
  output logic                         s_tready,
  input  logic [thrp_pkg::BYTE_W-1:0]  s_tdata,   // [7:0] data_byte
  input  logic                         s_tlast,   // last_byte
  output logic                         m_tvalid,
  input  logic                         m_tready,
  // [7:0] hash_byte, [15:8] record_number, [21:16] byte_position,
  // [22] record_done, [24:23] status, [31:25] zero
  output logic [thrp_pkg::TDATA_W-1:0] m_tdata,
  output logic [thrp_pkg::TUSER_W-1:0] m_tuser,   // [0] is_hash, [1] kind
  output logic                         m_tlast    // packet_end
);

  logic                        in_valid;
  logic [thrp_pkg::BYTE_W-1:0] in_byte;
  logic                        in_last;
  logic                        advance;
  logic                        step;
  thrp_pkg::result_t           result;
  thrp_pkg::result_t           out_res;

  assign advance  = !m_tvalid || m_tready;
  assign s_tready = !in_valid || advance;
  assign step     = in_valid && advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_byte <= s_tdata;
      in_last <= s_tlast;
    end
  end

  thrp_parse #(
    .SHORT_LEN   (SHORT_LEN),
    .LONG_LEN    (LONG_LEN),
    .MAX_RECORDS (MAX_RECORDS)
  ) u_parse (
    .clk       (clk),
    .rst       (rst),
    .step      (step),
    .data_byte (in_byte),
    .last_byte (in_last),
    .result    (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      out_res <= result;
    end
  end

  assign m_tdata = {7'b0, out_res.status, out_res.record_done, out_res.byte_position,
                    out_res.record_number, out_res.hash_byte};
  assign m_tuser = {out_res.kind, out_res.is_hash};
  assign m_tlast = out_res.packet_end;

endmodule
